### rtl/dotq_pkg.sv
package dotq_pkg;

  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_HANDLE_COUNT = 64;
  localparam int DEF_TIME_BITS    = 48;

  localparam int MODE_W   = 3;
  localparam int DELAY_W  = 32;
  localparam int HANDLE_W = 6;
  localparam int TAG_W    = 16;
  localparam int STAT_W   = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_SUBMIT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXECUTE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REVOKE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REVOKE_ALL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COMPLETE   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] RES_OK          = 3'd0;
  localparam logic [STAT_W-1:0] RES_FULL        = 3'd1;
  localparam logic [STAT_W-1:0] RES_BUSY        = 3'd2;
  localparam logic [STAT_W-1:0] RES_WRONG_STATE = 3'd3;
  localparam logic [STAT_W-1:0] RES_NOT_READY   = 3'd4;

  // per-handle task states
  localparam logic [STAT_W-1:0] TS_IDLE       = 3'd0;
  localparam logic [STAT_W-1:0] TS_PENDING    = 3'd1;
  localparam logic [STAT_W-1:0] TS_PROCESSING = 3'd2;
  localparam logic [STAT_W-1:0] TS_REVOKED    = 3'd3;
  localparam logic [STAT_W-1:0] TS_DONE       = 3'd4;
  localparam logic [STAT_W-1:0] TS_DONE_ERR   = 3'd5;

endpackage

### rtl/dotq_status_mem.sv
module dotq_status_mem #(
  parameter int HANDLE_COUNT = dotq_pkg::DEF_HANDLE_COUNT,
  parameter int AW           = $clog2(HANDLE_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [AW-1:0]               raddr,
  output logic [dotq_pkg::STAT_W-1:0] rdata,
  input  logic                        wen,
  input  logic [AW-1:0]               waddr,
  input  logic [dotq_pkg::STAT_W-1:0] wdata
);

  logic [dotq_pkg::STAT_W-1:0] mem [HANDLE_COUNT];
  logic [HANDLE_COUNT-1:0]     written;
  logic [dotq_pkg::STAT_W-1:0] mem_q;
  logic                        written_q;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // entries never written read as idle
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wen) begin
        written[waddr] <= 1'b1;
      end
      written_q <= written[raddr];
    end
  end

  assign rdata = written_q ? mem_q : dotq_pkg::TS_IDLE;

endmodule

### rtl/deadline_ordered_task_queue.sv
// deadline ordered task queue: fire-time sorted queue plus per-handle status table
// sequence: the accepting edge, S_R1 (status read), S_R2 as well for execute (head status read), then S_DONE
// registers the result; revoke all walks the queued entries (read-modify-write of the status memory)
// one item at a time: no new item is taken while one is in flight;
// the next item is taken once the result is in the output reg, so a held output stalls input
// reset (rst, synchronous): queue empties, every handle reads idle, output register empties
module deadline_ordered_task_queue #(
  parameter int QUEUE_DEPTH  = dotq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_COUNT = dotq_pkg::DEF_HANDLE_COUNT,
  parameter int TIME_BITS    = dotq_pkg::DEF_TIME_BITS,
  parameter int CW           = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dotq_pkg::MODE_W-1:0]   mode,
  input  logic [TIME_BITS-1:0]          now_time,
  input  logic [dotq_pkg::DELAY_W-1:0]  delay_ticks,
  input  logic [dotq_pkg::HANDLE_W-1:0] handle,
  input  logic [dotq_pkg::TAG_W-1:0]    task_tag,
  input  logic                          completed_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dotq_pkg::STAT_W-1:0]   status,
  output logic                          fired,
  output logic [dotq_pkg::HANDLE_W-1:0] fired_handle,
  output logic [dotq_pkg::TAG_W-1:0]    fired_tag,
  output logic [dotq_pkg::STAT_W-1:0]   task_status,
  output logic                          revoke_done,
  output logic [CW-1:0]                 entries_queued,
  output logic                          head_due,
  output logic [TIME_BITS-1:0]          next_fire_time
);

  localparam int AW = $clog2(HANDLE_COUNT);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int HW = dotq_pkg::HANDLE_W;
  localparam int SW = dotq_pkg::STAT_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_R1      = 3'd1;  // input handle status arrives
  localparam logic [2:0] S_R2      = 3'd2;  // head handle status arrives
  localparam logic [2:0] S_WALK_RD = 3'd3;  // revoke all: read status of one entry
  localparam logic [2:0] S_WALK_WR = 3'd4;  // revoke all: write it back
  localparam logic [2:0] S_DONE    = 3'd5;  // load output register

  logic [2:0] state;

  // latched item
  logic [dotq_pkg::MODE_W-1:0] m_mode;
  logic [TIME_BITS-1:0]        m_now;
  logic [dotq_pkg::DELAY_W-1:0] m_delay;
  logic [HW-1:0]               m_handle;
  logic [dotq_pkg::TAG_W-1:0]  m_tag;
  logic                        m_ok;
  logic [SW-1:0]               hstat;

  // queue cells, kept sorted by fire time
  logic [TIME_BITS-1:0]        q_time   [QUEUE_DEPTH];
  logic [HW-1:0]               q_handle [QUEUE_DEPTH];
  logic [dotq_pkg::TAG_W-1:0]  q_tag    [QUEUE_DEPTH];
  logic [CW-1:0]               count;
  logic [IW-1:0]               widx;

  // step result, held until the output register is free
  logic [SW-1:0]               r_status;
  logic                        r_fired;
  logic [HW-1:0]               r_fh;
  logic [dotq_pkg::TAG_W-1:0]  r_ftag;
  logic [SW-1:0]               r_tstat;
  logic                        r_revoked;

  // status memory port
  logic [AW-1:0] raddr, waddr;
  logic          wen;
  logic [SW-1:0] wdata, rdata;

  dotq_status_mem #(
    .HANDLE_COUNT(HANDLE_COUNT),
    .AW          (AW)
  ) u_status (
    .clk  (clk),
    .rst  (rst),
    .raddr(raddr),
    .rdata(rdata),
    .wen  (wen),
    .waddr(waddr),
    .wdata(wdata)
  );

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // handle to memory address and range check
  logic [31:0]   in_h_ext, m_h_ext, head_h_ext, walk_h_ext;
  logic [AW-1:0] in_addr, m_addr, head_addr, walk_addr;
  logic          m_hvalid, head_hvalid;

  assign in_h_ext    = 32'(handle);
  assign m_h_ext     = 32'(m_handle);
  assign head_h_ext  = 32'(q_handle[0]);
  assign walk_h_ext  = 32'(q_handle[widx]);
  assign in_addr     = in_h_ext[AW-1:0];
  assign m_addr      = m_h_ext[AW-1:0];
  assign head_addr   = head_h_ext[AW-1:0];
  assign walk_addr   = walk_h_ext[AW-1:0];
  assign m_hvalid    = m_h_ext < 32'(HANDLE_COUNT);
  assign head_hvalid = head_h_ext < 32'(HANDLE_COUNT);

  // submit: fire time, busy search and insert position over all cells at once
  logic [TIME_BITS-1:0]   fire;
  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] hmatch;
  logic                   queued;
  logic                   head_ready;

  assign fire = m_now + TIME_BITS'(m_delay);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i]     = (CW'(i) < count) && (q_time[i] <= fire);
      hmatch[i] = (CW'(i) < count) && (q_handle[i] == m_handle);
    end
  end

  assign queued     = |hmatch;
  assign head_ready = (count != '0) && (m_now >= q_time[0]);

  // decisions of the first compute state
  logic do_insert;
  always_comb begin
    do_insert = 1'b0;
    if (state == S_R1 && m_mode == dotq_pkg::MODE_SUBMIT && m_hvalid &&
        rdata != dotq_pkg::TS_PENDING && rdata != dotq_pkg::TS_PROCESSING &&
        !queued && count < CW'(QUEUE_DEPTH)) begin
      do_insert = 1'b1;
    end
  end

  logic do_pop;
  assign do_pop = (state == S_R2);

  // outcome of the first compute state, taken as one set of values
  logic [SW-1:0] r1_status, r1_tstat;
  logic          r1_revoked;
  logic [2:0]    r1_state;
  always_comb begin
    r1_status  = dotq_pkg::RES_OK;
    r1_tstat   = m_hvalid ? rdata : dotq_pkg::TS_IDLE;
    r1_revoked = 1'b0;
    r1_state   = S_DONE;
    case (m_mode)
      dotq_pkg::MODE_SUBMIT: begin
        if (!m_hvalid) begin
          r1_status = dotq_pkg::RES_WRONG_STATE;
        end else if (rdata == dotq_pkg::TS_PENDING ||
                     rdata == dotq_pkg::TS_PROCESSING || queued) begin
          r1_status = dotq_pkg::RES_BUSY;
        end else if (!do_insert) begin
          r1_status = dotq_pkg::RES_FULL;
        end else begin
          r1_tstat = dotq_pkg::TS_PENDING;
        end
      end
      dotq_pkg::MODE_EXECUTE: begin
        if (head_ready) begin
          r1_state = S_R2;
        end else begin
          r1_status = dotq_pkg::RES_NOT_READY;
        end
      end
      dotq_pkg::MODE_REVOKE: begin
        if (m_hvalid && rdata == dotq_pkg::TS_PENDING) begin
          r1_revoked = 1'b1;
          r1_tstat   = dotq_pkg::TS_REVOKED;
        end else if (m_hvalid && rdata == dotq_pkg::TS_REVOKED) begin
          r1_revoked = 1'b1;
        end else begin
          r1_status = dotq_pkg::RES_WRONG_STATE;
        end
      end
      dotq_pkg::MODE_REVOKE_ALL: begin
        r1_revoked = 1'b1;
        // a pending handle always has a queued entry, so the walk revokes it
        if (m_hvalid && rdata == dotq_pkg::TS_PENDING) begin
          r1_tstat = dotq_pkg::TS_REVOKED;
        end
        if (count != '0) begin
          r1_state = S_WALK_RD;
        end
      end
      dotq_pkg::MODE_COMPLETE: begin
        if (m_hvalid && rdata == dotq_pkg::TS_PROCESSING) begin
          r1_tstat = m_ok ? dotq_pkg::TS_DONE : dotq_pkg::TS_DONE_ERR;
        end else begin
          r1_status = dotq_pkg::RES_WRONG_STATE;
        end
      end
      default: begin
        r1_status = dotq_pkg::RES_OK;
      end
    endcase
  end

  // memory read and write port control
  always_comb begin
    raddr = in_addr;
    wen   = 1'b0;
    waddr = m_addr;
    wdata = dotq_pkg::TS_IDLE;
    unique case (state)
      S_IDLE: begin
        raddr = in_addr;
      end
      S_R1: begin
        raddr = head_addr;
        case (m_mode)
          dotq_pkg::MODE_SUBMIT: begin
            wen   = do_insert;
            wdata = dotq_pkg::TS_PENDING;
          end
          dotq_pkg::MODE_REVOKE: begin
            wen   = m_hvalid && rdata == dotq_pkg::TS_PENDING;
            wdata = dotq_pkg::TS_REVOKED;
          end
          dotq_pkg::MODE_COMPLETE: begin
            wen   = m_hvalid && rdata == dotq_pkg::TS_PROCESSING;
            wdata = m_ok ? dotq_pkg::TS_DONE : dotq_pkg::TS_DONE_ERR;
          end
          default: begin
            wen = 1'b0;
          end
        endcase
      end
      S_R2: begin
        wen   = head_hvalid && rdata == dotq_pkg::TS_PENDING;
        waddr = head_addr;
        wdata = dotq_pkg::TS_PROCESSING;
      end
      S_WALK_RD: begin
        raddr = walk_addr;
      end
      S_WALK_WR: begin
        wen   = rdata == dotq_pkg::TS_PENDING;
        waddr = walk_addr;
        wdata = dotq_pkg::TS_REVOKED;
      end
      S_DONE: begin
        raddr = in_addr;
      end
      default: begin
        raddr = in_addr;
      end
    endcase
  end

  // queue cells: sorted insert, head pop
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
            q_time[i]   <= fire;
            q_handle[i] <= m_handle;
            q_tag[i]    <= m_tag;
          end else begin
            q_time[i]   <= q_time[(i == 0) ? 0 : i - 1];
            q_handle[i] <= q_handle[(i == 0) ? 0 : i - 1];
            q_tag[i]    <= q_tag[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_time[i]   <= q_time[i + 1];
        q_handle[i] <= q_handle[i + 1];
        q_tag[i]    <= q_tag[i + 1];
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      m_mode   <= mode;
      m_now    <= now_time;
      m_delay  <= delay_ticks;
      m_handle <= handle;
      m_tag    <= task_tag;
      m_ok     <= completed_ok;
    end
    if (state == S_R1) begin
      hstat <= m_hvalid ? rdata : dotq_pkg::TS_IDLE;
    end
  end

  // sequencer and step result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the load in S_DONE covers the case of a drain and a reload in the same cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_R1;
          end
        end
        S_R1: begin
          r_status  <= r1_status;
          r_fired   <= 1'b0;
          r_fh      <= '0;
          r_ftag    <= '0;
          r_revoked <= r1_revoked;
          r_tstat   <= r1_tstat;
          state     <= r1_state;
          widx      <= '0;
          if (do_insert) begin
            count <= count + CW'(1);
          end
        end
        S_R2: begin
          // pending head is dispatched, revoked head is dropped silently
          if (head_hvalid && rdata == dotq_pkg::TS_PENDING) begin
            r_fired <= 1'b1;
            r_fh    <= q_handle[0];
            r_ftag  <= q_tag[0];
            r_tstat <= dotq_pkg::TS_PROCESSING;
          end else begin
            r_tstat <= hstat;
          end
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_WALK_RD: begin
          state <= S_WALK_WR;
        end
        S_WALK_WR: begin
          if (CW'(widx) + CW'(1) >= count) begin
            count <= '0;
            state <= S_DONE;
          end else begin
            widx  <= widx + IW'(1);
            state <= S_WALK_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= r_status;
            fired          <= r_fired;
            fired_handle   <= r_fh;
            fired_tag      <= r_ftag;
            task_status    <= r_tstat;
            revoke_done    <= r_revoked;
            entries_queued <= count;
            head_due       <= head_ready;
            next_fire_time <= (count != '0) ? q_time[0] : '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // the two head entries are in fire-time order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> q_time[0] <= q_time[1])
    else $error("queue head out of order");

  // a dispatch always reports ok and processing
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == dotq_pkg::RES_OK &&
                           task_status == dotq_pkg::TS_PROCESSING)
    else $error("dispatch with bad status");

  // an accepted item starts with the status read
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_R1)
    else $error("accepted item not sequenced");

endmodule

### tb/tb_deadline_ordered_task_queue.sv
`timescale 1ns / 1ps

module tb_deadline_ordered_task_queue;

  localparam int QDEPTH = dotq_pkg::DEF_QUEUE_DEPTH;
  localparam int NHANDLE = dotq_pkg::DEF_HANDLE_COUNT;
  localparam int TB = dotq_pkg::DEF_TIME_BITS;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam longint CYCLE_LIMIT = 2000000;

  // query has no package name; modes 6 and 7 behave the same way
  localparam logic [dotq_pkg::MODE_W-1:0] MODE_QUERY = 3'd5;

  // one result item as a struct, so the compare can walk it
  typedef struct packed {
    logic [dotq_pkg::STAT_W-1:0]   status;
    logic                          fired;
    logic [dotq_pkg::HANDLE_W-1:0] fired_handle;
    logic [dotq_pkg::TAG_W-1:0]    fired_tag;
    logic [dotq_pkg::STAT_W-1:0]   task_status;
    logic                          revoke_done;
    logic [CW-1:0]                 entries_queued;
    logic                          head_due;
    logic [TB-1:0]                 next_fire_time;
  } sched_result_t;

  typedef struct packed {
    logic [dotq_pkg::MODE_W-1:0]   mode;
    logic [TB-1:0]                 now_time;
    logic [dotq_pkg::DELAY_W-1:0]  delay_ticks;
    logic [dotq_pkg::HANDLE_W-1:0] handle;
    logic [dotq_pkg::TAG_W-1:0]    task_tag;
    logic                          completed_ok;
  } sched_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dotq_pkg::MODE_W-1:0] mode = '0;
  logic [TB-1:0] now_time = '0;
  logic [dotq_pkg::DELAY_W-1:0] delay_ticks = '0;
  logic [dotq_pkg::HANDLE_W-1:0] handle = '0;
  logic [dotq_pkg::TAG_W-1:0] task_tag = '0;
  logic completed_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dotq_pkg::STAT_W-1:0] status;
  logic fired;
  logic [dotq_pkg::HANDLE_W-1:0] fired_handle;
  logic [dotq_pkg::TAG_W-1:0] fired_tag;
  logic [dotq_pkg::STAT_W-1:0] task_status;
  logic revoke_done;
  logic [CW-1:0] entries_queued;
  logic head_due;
  logic [TB-1:0] next_fire_time;

  deadline_ordered_task_queue i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .now_time(now_time), .delay_ticks(delay_ticks),
    .handle(handle), .task_tag(task_tag), .completed_ok(completed_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .fired(fired), .fired_handle(fired_handle),
    .fired_tag(fired_tag), .task_status(task_status), .revoke_done(revoke_done),
    .entries_queued(entries_queued), .head_due(head_due),
    .next_fire_time(next_fire_time)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: a sorted copy of the queue and the handle table
  logic [TB-1:0]                 q_fire[QDEPTH];
  logic [dotq_pkg::HANDLE_W-1:0] q_handle[QDEPTH];
  logic [dotq_pkg::TAG_W-1:0]    q_tag[QDEPTH];
  int                            q_count;
  logic [dotq_pkg::STAT_W-1:0]   task_state[NHANDLE];

  sched_result_t pending_results[$];
  int  err_count = 0;
  longint cycle_count = 0;

  // idling knobs: two in percent and a hold-off flag
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_holdoff = 1'b0;

  // the clock advances a notion of "now" that the sender carries
  logic [TB-1:0] tick_now = '0;

  function automatic bit handle_in_queue(logic [dotq_pkg::HANDLE_W-1:0] h);
    for (int i = 0; i < q_count; i++)
      if (q_handle[i] == h) return 1'b1;
    return 1'b0;
  endfunction

  // advance the predictor by one request and return the result it causes
  function automatic sched_result_t schedule_step(sched_req_t r);
    sched_result_t res;
    logic [TB-1:0] fire;
    int pos;
    res = '0;
    case (r.mode)
      dotq_pkg::MODE_SUBMIT: begin
        if (task_state[r.handle] == dotq_pkg::TS_PENDING ||
            task_state[r.handle] == dotq_pkg::TS_PROCESSING ||
            handle_in_queue(r.handle)) begin
          res.status = dotq_pkg::RES_BUSY;
        end else if (q_count >= QDEPTH) begin
          res.status = dotq_pkg::RES_FULL;
        end else begin
          fire = r.now_time + TB'(r.delay_ticks);
          pos = 0;
          while (pos < q_count && q_fire[pos] <= fire) pos++;
          for (int i = q_count; i > pos; i--) begin
            q_fire[i] = q_fire[i-1];
            q_handle[i] = q_handle[i-1];
            q_tag[i] = q_tag[i-1];
          end
          q_fire[pos] = fire;
          q_handle[pos] = r.handle;
          q_tag[pos] = r.task_tag;
          q_count++;
          task_state[r.handle] = dotq_pkg::TS_PENDING;
        end
      end
      dotq_pkg::MODE_EXECUTE: begin
        if (q_count > 0 && r.now_time >= q_fire[0]) begin
          if (task_state[q_handle[0]] == dotq_pkg::TS_PENDING) begin
            task_state[q_handle[0]] = dotq_pkg::TS_PROCESSING;
            res.fired = 1'b1;
            res.fired_handle = q_handle[0];
            res.fired_tag = q_tag[0];
          end
          for (int i = 1; i < q_count; i++) begin
            q_fire[i-1] = q_fire[i];
            q_handle[i-1] = q_handle[i];
            q_tag[i-1] = q_tag[i];
          end
          q_count--;
        end else begin
          res.status = dotq_pkg::RES_NOT_READY;
        end
      end
      dotq_pkg::MODE_REVOKE: begin
        if (task_state[r.handle] == dotq_pkg::TS_PENDING) begin
          task_state[r.handle] = dotq_pkg::TS_REVOKED;
          res.revoke_done = 1'b1;
        end else if (task_state[r.handle] == dotq_pkg::TS_REVOKED) begin
          res.revoke_done = 1'b1;
        end else begin
          res.status = dotq_pkg::RES_WRONG_STATE;
        end
      end
      dotq_pkg::MODE_REVOKE_ALL: begin
        for (int i = 0; i < q_count; i++)
          if (task_state[q_handle[i]] == dotq_pkg::TS_PENDING)
            task_state[q_handle[i]] = dotq_pkg::TS_REVOKED;
        q_count = 0;
        res.revoke_done = 1'b1;
      end
      dotq_pkg::MODE_COMPLETE: begin
        if (task_state[r.handle] == dotq_pkg::TS_PROCESSING)
          task_state[r.handle] = r.completed_ok ? dotq_pkg::TS_DONE : dotq_pkg::TS_DONE_ERR;
        else
          res.status = dotq_pkg::RES_WRONG_STATE;
      end
      default: ;
    endcase
    res.task_status = res.fired ? task_state[res.fired_handle] : task_state[r.handle];
    res.entries_queued = CW'(q_count);
    res.head_due = (q_count > 0 && r.now_time >= q_fire[0]);
    res.next_fire_time = (q_count > 0) ? q_fire[0] : '0;
    return res;
  endfunction

  // send one item; the expectation is queued once the item is accepted
  task automatic send_req(sched_req_t r, bit typed, sched_result_t typed_res);
    sched_result_t predicted;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= r.mode;
    now_time <= r.now_time;
    delay_ticks <= r.delay_ticks;
    handle <= r.handle;
    task_tag <= r.task_tag;
    completed_ok <= r.completed_ok;
    // stall only moves at rising edges, so its value here holds up to the next one
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predicted = schedule_step(r);
    // typed rows double-check the predictor where the answer is obvious
    if (typed && predicted !== typed_res) begin
      err_count++;
      if (err_count <= 10)
        $display("table row disagrees: typed %h predicted %h", typed_res, predicted);
    end
    pending_results.push_back(predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver side: stall at random, or hold off during a pressure phase
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= recv_holdoff ||
                      (recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, fired, fired_handle, fired_tag, task_status, revoke_done,
              entries_queued, head_due, next_fire_time};
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // build a random request; mostly well-formed traffic around live handles
  function automatic sched_req_t random_req(int handle_span);
    sched_req_t r;
    int pick;
    r.now_time = tick_now;
    pick = $urandom_range(99, 0);
    if (pick < 35) r.mode = dotq_pkg::MODE_SUBMIT;
    else if (pick < 65) r.mode = dotq_pkg::MODE_EXECUTE;
    else if (pick < 75) r.mode = dotq_pkg::MODE_REVOKE;
    else if (pick < 78) r.mode = dotq_pkg::MODE_REVOKE_ALL;
    else if (pick < 92) r.mode = dotq_pkg::MODE_COMPLETE;
    else r.mode = dotq_pkg::MODE_W'($urandom_range(7, 5));
    case ($urandom_range(9, 0))
      0: r.delay_ticks = $urandom();
      1: r.delay_ticks = '1;
      default: r.delay_ticks = $urandom_range(40, 0);
    endcase
    r.handle = dotq_pkg::HANDLE_W'($urandom_range(handle_span - 1, 0));
    if ($urandom_range(19, 0) == 0) r.handle = dotq_pkg::HANDLE_W'($urandom());
    r.task_tag = dotq_pkg::TAG_W'($urandom());
    r.completed_ok = 1'($urandom_range(1, 0));
    return r;
  endfunction

  typedef struct {
    sched_req_t    req;
    bit            typed;
    sched_result_t res;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    sched_req_t r;
    sched_result_t x;
    logic [TB-1:0] big_now;

    for (int i = 0; i < NHANDLE; i++) task_state[i] = dotq_pkg::TS_IDLE;
    q_count = 0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_fire[i] = '0;
      q_handle[i] = '0;
      q_tag[i] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    big_now = '1;
    // directed table: after reset, extremes, error codes; rest predicted only
    x = '0; x.status = dotq_pkg::RES_NOT_READY;
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, '0, '0, '0, '0, 1'b0}, 1'b1, x});
    x = '0; x.status = dotq_pkg::RES_WRONG_STATE;
    rows.push_back('{'{dotq_pkg::MODE_REVOKE, '0, '0, 6'd63, '0, 1'b0}, 1'b1, x});
    rows.push_back('{'{dotq_pkg::MODE_COMPLETE, '0, '0, 6'd5, '0, 1'b1}, 1'b1, x});
    x = '0;
    rows.push_back('{'{MODE_QUERY, big_now, '1, 6'd63, '1, 1'b1}, 1'b1, x});
    x = '0; x.revoke_done = 1'b1;
    rows.push_back('{'{dotq_pkg::MODE_REVOKE_ALL, '0, '0, '0, '0, 1'b0}, 1'b1, x});
    // submit with max delay and now: fire time wraps
    rows.push_back('{'{dotq_pkg::MODE_SUBMIT, big_now, '1, 6'd63, 16'hffff, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_SUBMIT, TB'(10), '0, 6'd0, 16'h0000, 1'b0}, 1'b0, x});
    // same handle again: busy
    rows.push_back('{'{dotq_pkg::MODE_SUBMIT, TB'(10), 32'd5, 6'd0, 16'h1234, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_SUBMIT, TB'(10), '0, 6'd1, 16'haaaa, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_SUBMIT, TB'(10), 32'd3, 6'd2, 16'h5555, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_REVOKE, TB'(10), '0, 6'd1, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_REVOKE, TB'(10), '0, 6'd1, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, TB'(10), '0, '0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, TB'(10), '0, '0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, TB'(12), '0, '0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, TB'(13), '0, '0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_REVOKE, TB'(13), '0, 6'd0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_COMPLETE, TB'(13), '0, 6'd0, '0, 1'b1}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_COMPLETE, TB'(13), '0, 6'd2, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{MODE_QUERY, TB'(13), '0, 6'd2, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{3'd7, TB'(13), '0, 6'd0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_EXECUTE, big_now, '0, '0, '0, 1'b0}, 1'b0, x});
    rows.push_back('{'{dotq_pkg::MODE_REVOKE_ALL, TB'(13), '0, '0, '0, 1'b0}, 1'b0, x});
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);
    wait_drained();

    // fill the queue past full, starting while the receiver holds off
    fork
      begin
        recv_holdoff = 1'b1;
        repeat (200) @(negedge clk);
        recv_holdoff = 1'b0;
      end
      for (int i = 0; i < QDEPTH + 3; i++) begin
        r = '{dotq_pkg::MODE_SUBMIT, TB'(100), dotq_pkg::DELAY_W'($urandom_range(9, 0)),
              dotq_pkg::HANDLE_W'(i + 10), dotq_pkg::TAG_W'($urandom()), 1'b0};
        send_req(r, 1'b0, x);
      end
    join
    wait_drained();
    tick_now = TB'(100);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 81 : 14) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 81 : 14) : 0;
      for (int n = 0; n < 480; n++) begin
        if ($urandom_range(3, 0) == 0) tick_now = tick_now + TB'($urandom_range(6, 0));
        if ($urandom_range(199, 0) == 0) tick_now = TB'({$urandom(), $urandom()});
        send_req(random_req(ph == 0 ? 8 : 24), 1'b0, x);
      end
      // sender pauses until every result is back
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (100) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dotq_pkg.sv
rtl/dotq_status_mem.sv
rtl/deadline_ordered_task_queue.sv
tb/tb_deadline_ordered_task_queue.sv
